FILE: src/fsr_pkg.sv
// Package with the constants and types of the framebuffer scanline renderer.
package fsr_pkg;

    localparam int FB_WORDS       = 65536;
    localparam int FB_AW          = $clog2(FB_WORDS);
    localparam int PAL_ENTRIES    = 256;
    localparam int PAL_AW         = $clog2(PAL_ENTRIES);
    localparam int LINE_PIXELS    = 320;
    localparam int COL_W          = $clog2(LINE_PIXELS + 1);
    localparam int RUN_W          = 9;
    localparam int LINES_SHORT    = 224;
    localparam int LINES_TALL     = 240;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 2;

    typedef enum logic [1:0] {
        OP_FB_WRITE   = 2'd0,
        OP_PAL_WRITE  = 2'd1,
        OP_START_LINE = 2'd2,
        OP_PIXEL      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_BLANK  = 2'd0,
        MODE_PACKED = 2'd1,
        MODE_DIRECT = 2'd2,
        MODE_RUN    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_DISPLAY_MODE  = 2'd0,
        CFG_TALL_LINES    = 2'd1,
        CFG_PRIORITY_SWAP = 2'd2,
        CFG_DOT_SHIFT     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SRC_PACKED    = 2'd0,
        SRC_DIRECT    = 2'd1,
        SRC_RUN_FETCH = 2'd2,
        SRC_RUN_HOLD  = 2'd3
    } t_src;

endpackage

FILE: src/framebuffer_scanline_renderer.sv
// Top level of the framebuffer scanline renderer with its framebuffer and palette memories.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------------------
//  input   | in        | i_in_valid / o_in_stall   | operation, addresses, data, line, backdrop
//  output  | out       | o_out_valid / i_out_stall | pixel_color, take_mask
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item is taken every cycle unless input stalls; a pixel result reaches the output
// register via the framebuffer read at the transfer, palette read, colour and mask stage.
// After reset the framebuffer is cleared one word a cycle, all 65536 words, while input stalls.
// The pipeline halts only when a finished result is blocked and the last stage holds another.
module framebuffer_scanline_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_fb_address,
    input  logic [7:0]  i_palette_index,
    input  logic [15:0] i_write_data,
    input  logic [7:0]  i_line_number,
    input  logic [3:0]  i_backdrop_bits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_pixel_color,
    output logic [3:0]  o_take_mask,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [fsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fsr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fsr_pkg::*;

    logic [15:0] r_fb_mem [FB_WORDS];
    logic [15:0] r_pal_mem [PAL_ENTRIES];
    logic [PAL_ENTRIES-1:0] r_pal_valid;

    t_mode r_display_mode;
    logic  r_tall_lines;
    logic  r_priority_swap;
    logic  r_dot_shift;

    logic             r_clearing;
    logic [FB_AW-1:0] r_clr_addr;

    logic [15:0]      r_line_address, n_line_address;
    logic [COL_W-1:0] r_pixel_column, n_pixel_column;
    logic [RUN_W-1:0] r_run_left, n_run_left;
    logic [15:0]      r_run_color;
    logic             r_line_active, n_line_active;

    logic [15:0] r_fb_q;
    logic [15:0] r_pal_q;
    logic        r_pal_q_valid;

    logic        r_b_res, n_b_res;
    logic        r_b_blank, n_b_blank;
    t_src        r_b_src, n_b_src;
    logic        r_b_low_sel, n_b_low_sel;
    logic [3:0]  r_b_back;
    logic        r_b_line, n_b_line;
    logic        r_b_fetch, n_b_fetch;
    logic        r_b_pal_wr, n_b_pal_wr;
    logic [PAL_AW-1:0] r_b_pal_idx;
    logic [15:0] r_b_data;

    logic        r_c_res;
    logic        r_c_blank;
    t_src        r_c_src;
    logic [15:0] r_c_direct;
    logic [3:0]  r_c_back;

    logic        r_out_valid;
    logic [15:0] r_pixel_color;
    logic [3:0]  r_take_mask;

    logic              advance;
    logic              accept;
    t_op               op;
    logic [15:0]       la_eff;
    logic [RUN_W-1:0]  run_eff;
    logic [COL_W-1:0]  pos;
    logic [15:0]       rd_addr;
    logic [PAL_AW-1:0] pal_rd_idx;
    logic [15:0]       c_color;
    logic [15:0]       pal_color;
    logic              take;
    logic [7:0]        line_limit;

    assign advance    = !(r_out_valid && i_out_stall && r_c_res);
    assign o_in_stall = r_clearing || !advance;
    assign accept     = i_in_valid && !o_in_stall;
    assign op         = t_op'(i_operation);
    assign o_cfg_ready = 1'b1;

    assign la_eff  = r_b_line ? r_fb_q : r_line_address;
    assign run_eff = r_b_fetch ? {1'b0, r_fb_q[15:8]} : r_run_left;
    assign pos     = r_pixel_column + {{(COL_W-1){1'b0}}, r_dot_shift};
    assign line_limit = r_tall_lines ? 8'(LINES_TALL) : 8'(LINES_SHORT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode  <= MODE_BLANK;
            r_tall_lines    <= 1'b0;
            r_priority_swap <= 1'b0;
            r_dot_shift     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DISPLAY_MODE:  r_display_mode  <= t_mode'(i_cfg_data);
                CFG_TALL_LINES:    r_tall_lines    <= i_cfg_data[0];
                CFG_PRIORITY_SWAP: r_priority_swap <= i_cfg_data[0];
                CFG_DOT_SHIFT:     r_dot_shift     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + FB_AW'(1);
            if (r_clr_addr == {FB_AW{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        n_line_address = la_eff;
        n_run_left     = run_eff;
        n_pixel_column = r_pixel_column;
        n_line_active  = r_line_active;
        n_b_res        = 1'b0;
        n_b_blank      = 1'b0;
        n_b_src        = SRC_PACKED;
        n_b_low_sel    = 1'b0;
        n_b_line       = 1'b0;
        n_b_fetch      = 1'b0;
        n_b_pal_wr     = 1'b0;
        rd_addr        = la_eff;
        if (accept) begin
            unique case (op)
                OP_FB_WRITE: begin
                end
                OP_PAL_WRITE: begin
                    n_b_pal_wr = 1'b1;
                end
                OP_START_LINE: begin
                    rd_addr        = {8'd0, i_line_number};
                    n_b_line       = 1'b1;
                    n_pixel_column = '0;
                    n_run_left     = '0;
                    n_line_active  = (r_display_mode != MODE_BLANK) &&
                                     (i_line_number < line_limit);
                end
                OP_PIXEL: begin
                    n_b_res = 1'b1;
                    if (!r_line_active || r_display_mode == MODE_BLANK ||
                        r_pixel_column >= COL_W'(LINE_PIXELS)) begin
                        n_b_blank = 1'b1;
                    end else begin
                        n_pixel_column = r_pixel_column + COL_W'(1);
                        unique case (r_display_mode)
                            MODE_PACKED: begin
                                n_b_src     = SRC_PACKED;
                                n_b_low_sel = pos[0];
                                rd_addr     = la_eff + 16'(pos[COL_W-1:1]);
                            end
                            MODE_DIRECT: begin
                                n_b_src        = SRC_DIRECT;
                                n_line_address = la_eff + 16'd1;
                            end
                            MODE_RUN: begin
                                if (run_eff == '0) begin
                                    n_b_src        = SRC_RUN_FETCH;
                                    n_b_fetch      = 1'b1;
                                    n_line_address = la_eff + 16'd1;
                                end else begin
                                    n_b_src    = SRC_RUN_HOLD;
                                    n_run_left = run_eff - RUN_W'(1);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_fb_mem[r_clr_addr] <= '0;
        end else if (accept && op == OP_FB_WRITE) begin
            r_fb_mem[i_fb_address[FB_AW-1:0]] <= i_write_data;
        end
        if (advance) begin
            r_fb_q <= r_fb_mem[rd_addr[FB_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_address <= '0;
            r_pixel_column <= '0;
            r_run_left     <= '0;
            r_line_active  <= 1'b0;
            r_b_res        <= 1'b0;
            r_b_blank      <= 1'b0;
            r_b_src        <= SRC_PACKED;
            r_b_low_sel    <= 1'b0;
            r_b_line       <= 1'b0;
            r_b_fetch      <= 1'b0;
            r_b_pal_wr     <= 1'b0;
        end else if (advance) begin
            r_line_address <= n_line_address;
            r_pixel_column <= n_pixel_column;
            r_run_left     <= n_run_left;
            r_line_active  <= n_line_active;
            r_b_res        <= n_b_res;
            r_b_blank      <= n_b_blank;
            r_b_src        <= n_b_src;
            r_b_low_sel    <= n_b_low_sel;
            r_b_line       <= n_b_line;
            r_b_fetch      <= n_b_fetch;
            r_b_pal_wr     <= n_b_pal_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_back    <= i_backdrop_bits;
            r_b_pal_idx <= i_palette_index[PAL_AW-1:0];
            r_b_data    <= i_write_data;
        end
    end

    always_comb begin
        if (r_b_src == SRC_PACKED && !r_b_low_sel) begin
            pal_rd_idx = r_fb_q[15:8];
        end else begin
            pal_rd_idx = r_fb_q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_b_pal_wr) begin
            r_pal_mem[r_b_pal_idx] <= r_b_data;
        end
        if (advance) begin
            r_pal_q <= r_pal_mem[pal_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_valid   <= '0;
            r_pal_q_valid <= 1'b0;
        end else if (advance) begin
            r_pal_q_valid <= r_pal_valid[pal_rd_idx];
            if (r_b_pal_wr) begin
                r_pal_valid[r_b_pal_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_res   <= 1'b0;
            r_c_blank <= 1'b0;
            r_c_src   <= SRC_PACKED;
        end else if (advance) begin
            r_c_res   <= r_b_res;
            r_c_blank <= r_b_blank;
            r_c_src   <= r_b_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_c_direct <= r_fb_q;
            r_c_back   <= r_b_back;
        end
    end

    assign pal_color = r_pal_q_valid ? r_pal_q : 16'd0;

    always_comb begin
        case (r_c_src)
            SRC_DIRECT:   c_color = r_c_direct;
            SRC_RUN_HOLD: c_color = r_run_color;
            default:      c_color = pal_color;
        endcase
    end

    assign take = c_color[15] ^ r_priority_swap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_color <= '0;
        end else if (advance && r_c_res && !r_c_blank && r_c_src == SRC_RUN_FETCH) begin
            r_run_color <= pal_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_c_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_c_res) begin
            if (r_c_blank) begin
                r_pixel_color <= 16'd0;
                r_take_mask   <= 4'd0;
            end else begin
                r_pixel_color <= c_color | 16'h8000;
                r_take_mask   <= r_c_back | {4{take}};
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_color = r_pixel_color;
    assign o_take_mask   = r_take_mask;

endmodule
